// ===== rtl/core/chw_pkg.sv =====
// ----------------------------------------------------------------------------
// chw_pkg
// Shared types and constants of the channel heartbeat watchdog.
// ----------------------------------------------------------------------------
package chw_pkg;

  localparam int unsigned Channels  = 16;
  localparam int unsigned ChBits    = 4;
  localparam int unsigned TimeBits  = 32;
  localparam int unsigned TmoBits   = 18;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [TmoBits-1:0] FallbackTmo = 18'd1000;

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_MSG    = 3'd1,
    FUNC_EVENT  = 3'd2,
    FUNC_PLAN   = 3'd3,
    FUNC_CONFIG = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INACTIVE = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_STALE    = 3'd3,
    ST_ERROR    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    RS_NONE     = 4'd0,
    RS_HB_TMO   = 4'd1,
    RS_MSG_TMO  = 4'd2,
    RS_DEADLINE = 4'd3,
    RS_QOS      = 4'd4,
    RS_LIVELY   = 4'd5
  } reason_e;

  typedef enum logic [1:0] {
    EV_DEADLINE = 2'd0,
    EV_QOS      = 2'd1,
    EV_LIVELY   = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    CFG_CHECK  = 2'd0,
    CFG_STATUS = 2'd1,
    CFG_GRACE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_OUT,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  channel;
    logic [1:0]  event_kind;
    logic [2:0]  planned_reason;
    logic        enable;
    logic        is_heartbeat;
    logic [15:0] dl_period;
    logic [15:0] lv_lease;
    logic [17:0] timeout_request_ms;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  out_channel;
    logic [2:0]  status;
    logic [3:0]  reason;
    logic [31:0] age_ms;
    logic        last;
  } out_req_t;

  // per-channel record kept in the channel memory
  typedef struct packed {
    logic [TmoBits-1:0]  timeout;
    logic [TimeBits-1:0] last_msg;
    logic [TimeBits-1:0] last_rep;
  } chan_rec_t;

  // planned reason to report reason code
  function automatic logic [3:0] planned_code(input logic [2:0] p);
    logic [3:0] r;
    begin
      r = RS_NONE;
      if (p >= 3'd1 && p <= 3'd4) begin
        r = {1'b0, p} + 4'd5;
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/channel_heartbeat_watchdog.sv =====
// ----------------------------------------------------------------------------
// channel_heartbeat_watchdog
// Sixteen-channel liveness watchdog with rate-limited status reports.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid_i / in_stall_o / in_req_i) takes ticks,
// message arrivals, deadline, QoS and liveliness events, planned-state updates and channel setups.
// One output channel (out_valid_o / out_stall_i / out_req_o) delivers the
// status reports; last marks the final report caused by a request.
// Flow: one request at a time, in_stall_o is high until it is done. A
// non-sweep request passes memory read, evaluate and report/write back,
// then a flush step when it reports; a sweep tick visits all 16 channels,
// each through memory read, evaluate and report/write back, and ends with
// the flush step when it reports.
// Results: each report waits in a holding register until the next report
// or the end of the request is known, then moves to the output register.
// While out_stall_i is high the output is held and a second report stops
// the sequencer. Reset: registers return to their defaults, all channels
// disabled; the channel memory needs no clearing, entries are rewritten
// on setup before they are read.
// ----------------------------------------------------------------------------
module channel_heartbeat_watchdog (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  chw_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output chw_pkg::out_req_t               out_req_o,
  input  logic                            cfg_we_i,
  input  logic [chw_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [15:0]                     cfg_wdata_i
);
  import chw_pkg::*;

  // configuration registers
  logic [15:0] check_per_q, status_per_q, grace_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_per_q  <= 16'd100;
      status_per_q <= 16'd1000;
      grace_q      <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHECK:  check_per_q  <= cfg_wdata_i;
        CFG_STATUS: status_per_q <= cfg_wdata_i;
        CFG_GRACE:  grace_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-channel flag registers
  logic [Channels-1:0] en_q, kind_q, dl_on_q, lv_on_q, seen_q, pub_q;
  logic [2:0]          plan_q [Channels];
  logic [TimeBits-1:0] now_q;
  logic [15:0]         cnt_q;

  // channel memory, one read and one write port
  chan_rec_t mem [Channels];
  chan_rec_t rd_q;
  logic              mem_we;
  logic [ChBits-1:0] mem_wa, mem_ra;
  chan_rec_t         mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  // sequencer and report registers
  state_e            state_q, state_d;
  in_req_t           req_q;
  logic              sweep_q, sweep_d;
  logic [ChBits-1:0] ch_q, ch_d;
  out_req_t          pend_q, out_q, rep_now, pend_fl;
  logic              pend_v_q, out_valid_q;

  // evaluation of the channel held in ch_q
  logic [TimeBits-1:0] age, rep_el;
  logic                rate_ok, do_rep, ev_rep;
  logic [2:0]          st;
  logic [3:0]          rs;
  logic [TimeBits-1:0] rage;

  assign age    = now_q - rd_q.last_msg;
  assign rep_el = now_q - rd_q.last_rep;
  assign rate_ok = !pub_q[ch_q] || (rep_el >= {16'd0, status_per_q});

  always_comb begin
    st     = ST_OK;
    rs     = RS_NONE;
    rage   = '0;
    do_rep = 1'b0;
    ev_rep = 1'b0;
    if (sweep_q) begin
      if (en_q[ch_q]) begin
        do_rep = rate_ok;
        if (plan_q[ch_q] != 3'd0) begin
          st = ST_INACTIVE;
          rs = planned_code(plan_q[ch_q]);
        end else if (!seen_q[ch_q]) begin
          st = ST_UNKNOWN;
          rs = RS_HB_TMO;
        end else if (age > {14'd0, rd_q.timeout}) begin
          st   = ST_STALE;
          rs   = kind_q[ch_q] ? RS_HB_TMO : RS_MSG_TMO;
          rage = age;
        end else begin
          rage = age;
        end
      end
    end else begin
      case (req_q.func)
        FUNC_MSG: begin
          if (en_q[ch_q]) begin
            do_rep = rate_ok;
            if (plan_q[ch_q] != 3'd0) begin
              st = ST_INACTIVE;
              rs = planned_code(plan_q[ch_q]);
            end
          end
        end
        FUNC_EVENT: begin
          if (en_q[ch_q] && plan_q[ch_q] == 3'd0) begin
            rage = seen_q[ch_q] ? age : '0;
            if (req_q.event_kind == EV_DEADLINE && dl_on_q[ch_q]) begin
              ev_rep = 1'b1; st = ST_STALE; rs = RS_DEADLINE;
            end else if (req_q.event_kind == EV_QOS) begin
              ev_rep = 1'b1; st = ST_ERROR; rs = RS_QOS;
            end else if (req_q.event_kind == EV_LIVELY && lv_on_q[ch_q]) begin
              ev_rep = 1'b1; st = ST_ERROR; rs = RS_LIVELY;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // derived timeout for channel setup
  logic [16:0] dmax;
  logic [17:0] tmo;
  assign dmax = {1'b0, (req_q.dl_period > req_q.lv_lease) ?
                req_q.dl_period : req_q.lv_lease} + {1'b0, grace_q};
  always_comb begin
    tmo = req_q.timeout_request_ms;
    if (tmo == '0) begin
      tmo = (dmax == '0) ? FallbackTmo : {1'b0, dmax};
    end
  end

  logic cfg_skip;
  assign cfg_skip = req_q.timeout_request_ms == '0 && req_q.is_heartbeat &&
                    req_q.dl_period == '0 && req_q.lv_lease == '0;

  logic        in_acc, out_free, last_ch, emit, adv, tick_now, sweep_go;
  logic [15:0] cnt_inc;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_ch  = !sweep_q || (ch_q == ChBits'(Channels - 1));
  assign emit     = do_rep || ev_rep;
  // a channel step completes unless a second report meets a stalled output
  assign adv      = (state_q == S_OUT) && (!emit || !pend_v_q || out_free);
  assign tick_now = state_q == S_READ && !sweep_q && req_q.func == FUNC_TICK;
  assign cnt_inc  = cnt_q + 16'd1;
  assign sweep_go = tick_now && (cnt_inc >= check_per_q);

  // next state
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    ch_d    = ch_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_READ;
          sweep_d = 1'b0;
          ch_d    = in_req_i.channel;
        end
      end
      S_READ: begin
        // a tick that hits the check period becomes a sweep from channel 0
        if (sweep_go) begin
          sweep_d = 1'b1;
          ch_d    = '0;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (adv) begin
          if (last_ch) begin
            state_d = (emit || pend_v_q) ? S_FLUSH : S_IDLE;
          end else begin
            ch_d    = ch_q + ChBits'(1);
            state_d = S_READ;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_ra = ch_d;
    mem_we = 1'b0;
    mem_wa = ch_q;
    mem_wd = rd_q;
    if (adv && do_rep) begin
      mem_we = 1'b1;
      mem_wd.last_rep = now_q;
    end
    if (adv && !sweep_q && req_q.func == FUNC_MSG && en_q[ch_q]) begin
      mem_we = 1'b1;
      mem_wd.last_msg = now_q;
    end
    if (adv && !sweep_q && req_q.func == FUNC_CONFIG &&
        req_q.enable && !cfg_skip) begin
      mem_we = 1'b1;
      mem_wd.timeout  = tmo;
      mem_wd.last_msg = '0;
      mem_wd.last_rep = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sweep_q     <= 1'b0;
      ch_q        <= '0;
      now_q       <= '0;
      cnt_q       <= '0;
      en_q        <= '0;
      kind_q      <= '0;
      dl_on_q     <= '0;
      lv_on_q     <= '0;
      seen_q      <= '0;
      pub_q       <= '0;
      for (int i = 0; i < Channels; i++) plan_q[i] <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      ch_q    <= ch_d;
      // tick advances time once per request
      if (tick_now) begin
        now_q <= now_q + TimeBits'(1);
        cnt_q <= sweep_go ? 16'd0 : cnt_inc;
      end
      if (adv) begin
        if (do_rep) pub_q[ch_q] <= 1'b1;
        if (!sweep_q) begin
          case (req_q.func)
            FUNC_MSG: if (en_q[ch_q]) seen_q[ch_q] <= 1'b1;
            FUNC_PLAN: plan_q[ch_q] <= req_q.planned_reason;
            FUNC_CONFIG: begin
              if (!req_q.enable) begin
                en_q[ch_q]   <= 1'b0;
                seen_q[ch_q] <= 1'b0;
                pub_q[ch_q]  <= 1'b0;
              end else if (!cfg_skip) begin
                en_q[ch_q]    <= 1'b1;
                kind_q[ch_q]  <= req_q.is_heartbeat;
                dl_on_q[ch_q] <= req_q.dl_period != '0;
                lv_on_q[ch_q] <= req_q.lv_lease != '0;
                seen_q[ch_q]  <= 1'b0;
                pub_q[ch_q]   <= 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
  end

  // report of the current step and the held report with its last flag
  always_comb begin
    rep_now.out_channel = ch_q;
    rep_now.status      = st;
    rep_now.reason      = rs;
    rep_now.age_ms      = 32'(rage);
    rep_now.last        = 1'b0;
    pend_fl             = pend_q;
    pend_fl.last        = state_q == S_FLUSH;
  end

  // a report is held until the next one shows it was not the final one
  logic push_out;
  assign push_out = (adv && emit && pend_v_q) || (state_q == S_FLUSH && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv && emit) begin
        pend_v_q <= 1'b1;
      end else if (state_q == S_FLUSH && out_free) begin
        pend_v_q <= 1'b0;
      end
      if (push_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      pend_q <= rep_now;
    end
    if (push_out) begin
      out_q <= pend_fl;
    end
  end

  assign out_req_o   = out_q;
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = state_q != S_IDLE;

  // checks
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("report changed while stalled");

  a_idle_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> state_q == S_IDLE)
    else $error("request taken while busy");

  a_sweep_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sweep_q) |-> ch_q == '0)
    else $error("sweep did not start at channel zero");

endmodule
